// ===== sv/ice_pkg.sv =====
// Shared types, constants and helpers for the implication closure engine.
package ice_pkg;

    localparam int ATTR_COUNT = 32;
    localparam int MAX_RULES  = 64;
    localparam int SET_W      = 32;
    localparam int RULE_AW    = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
    localparam int CNT_W      = $clog2(MAX_RULES + 1);

    localparam logic [SET_W-1:0] ATTR_MASK =
        (ATTR_COUNT >= SET_W) ? {SET_W{1'b1}}
                              : SET_W'((64'd1 << ATTR_COUNT) - 64'd1);

    localparam logic [1:0] MODE_APPEND = 2'd0;
    localparam logic [1:0] MODE_CLEAR  = 2'd1;
    localparam logic [1:0] MODE_QUERY  = 2'd2;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_PREFIX = 2'd1,
        ST_FULL   = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_SWEEP
    } t_state;

    // Mask of all attributes below index p.
    function automatic logic [SET_W-1:0] prefix_mask(input logic [5:0] p);
        logic [63:0] m;
        if (p >= 6'(SET_W)) begin
            m = '1;
        end else begin
            m = (64'd1 << p) - 64'd1;
        end
        return m[SET_W-1:0];
    endfunction

endpackage

// ===== sv/ice_rule_ram.sv =====
// Single-port-write, registered-read memory holding the implication table.
module ice_rule_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 64,
    parameter int AW    = 6
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one entry per cycle.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Register the read word.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/implication_closure_engine.sv =====
// Top level: implication table, closure sequencer and result register.
//
// An append or clear leaves busy low, and the result word appears with
// o_valid on the next cycle. A query against an empty table also answers on
// the next cycle. Otherwise the sequencer sweeps the stored rules through
// the table memory, one rule per cycle through a single subset-test and
// merge unit, and the result word appears in the cycle after the last
// pass. Passes repeat until one adds nothing, which is at most one pass per
// newly added attribute plus one, bounded also by n+1 for n stored rules.
// The result word is shown for exactly one cycle with o_valid and must be
// taken then; the block never waits on the receiver. Table contents are
// not cleared at reset; only the rule count is, and only counted entries
// are ever read.
module implication_closure_engine (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [1:0]                 i_mode,
    input  logic [ice_pkg::SET_W-1:0]  i_premise_set,
    input  logic [ice_pkg::SET_W-1:0]  i_conclusion_set,
    input  logic [ice_pkg::SET_W-1:0]  i_start_set,
    input  logic [5:0]                 i_prefix_len,
    output logic                       o_valid,
    output logic [ice_pkg::SET_W-1:0]  o_closure_set,
    output logic                       o_success,
    output logic [1:0]                 o_status
);

    import ice_pkg::*;

    // Control state
    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic              r_dv, n_dv;
    logic              r_changed, n_changed;
    logic              r_valid, n_valid;

    // Payload state
    logic [SET_W-1:0]  r_cur, n_cur;
    logic [SET_W-1:0]  r_start, n_start;
    logic [SET_W-1:0]  r_pmask, n_pmask;
    logic [SET_W-1:0]  r_closure, n_closure;
    logic              r_success, n_success;
    t_status           r_status, n_status;

    // Memory port
    logic                  ram_we;
    logic [2*SET_W-1:0]    ram_wdata;
    logic [2*SET_W-1:0]    ram_rdata;
    logic [SET_W-1:0]      rd_premise;
    logic [SET_W-1:0]      rd_conclusion;

    // Shared subset-test and merge unit
    logic              rule_hit;
    logic [SET_W-1:0]  merged;
    logic              grew;
    logic [SET_W-1:0]  q_start;
    logic [SET_W-1:0]  q_pmask;

    assign ram_wdata     = {i_premise_set & ATTR_MASK, i_conclusion_set & ATTR_MASK};
    assign rd_premise    = ram_rdata[2*SET_W-1:SET_W];
    assign rd_conclusion = ram_rdata[SET_W-1:0];

    ice_rule_ram #(
        .DEPTH (MAX_RULES),
        .WIDTH (2*SET_W),
        .AW    (RULE_AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[RULE_AW-1:0]),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx[RULE_AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // Fire the rule when its premise lies inside the current set.
    assign rule_hit = ((rd_premise & ~r_cur) == '0);
    assign merged   = rule_hit ? (r_cur | rd_conclusion) : r_cur;
    assign grew     = (merged != r_cur);

    assign q_start = i_start_set & ATTR_MASK;
    assign q_pmask = prefix_mask(i_prefix_len) & ATTR_MASK;

    // Sequencer: next state, memory control and result word
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_dv      = 1'b0;
        n_changed = r_changed;
        n_valid   = 1'b0;
        n_cur     = r_cur;
        n_start   = r_start;
        n_pmask   = r_pmask;
        n_closure = r_closure;
        n_success = r_success;
        n_status  = r_status;
        ram_we    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_closure = '0;
                    n_success = 1'b1;
                    n_status  = ST_OK;
                    unique case (i_mode)
                        MODE_APPEND: begin
                            n_valid = 1'b1;
                            if (r_count < CNT_W'(MAX_RULES)) begin
                                ram_we  = 1'b1;
                                n_count = r_count + CNT_W'(1);
                            end else begin
                                n_success = 1'b0;
                                n_status  = ST_FULL;
                            end
                        end
                        MODE_CLEAR: begin
                            n_valid = 1'b1;
                            n_count = '0;
                        end
                        default: begin
                            // Query; the unused mode code behaves the same.
                            if (r_count == '0) begin
                                n_valid   = 1'b1;
                                n_closure = q_start;
                            end else begin
                                n_state   = S_SWEEP;
                                n_cur     = q_start;
                                n_start   = q_start;
                                n_pmask   = q_pmask;
                                n_idx     = '0;
                                n_changed = 1'b0;
                            end
                        end
                    endcase
                end
            end
            S_SWEEP: begin
                // Issue the next rule read.
                if (r_idx < r_count) begin
                    n_idx = r_idx + CNT_W'(1);
                    n_dv  = 1'b1;
                end
                // Merge the rule read last cycle.
                if (r_dv) begin
                    n_cur     = merged;
                    n_changed = r_changed | grew;
                    if (r_idx == r_count) begin
                        if (r_changed | grew) begin
                            // Pass added something: sweep again.
                            n_idx     = '0;
                            n_changed = 1'b0;
                        end else begin
                            n_state = S_IDLE;
                            n_valid = 1'b1;
                            if (((merged ^ r_start) & r_pmask) != '0) begin
                                n_closure = '0;
                                n_success = 1'b0;
                                n_status  = ST_PREFIX;
                            end else begin
                                n_closure = merged;
                                n_success = 1'b1;
                                n_status  = ST_OK;
                            end
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_idx     <= '0;
            r_dv      <= 1'b0;
            r_changed <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_idx     <= n_idx;
            r_dv      <= n_dv;
            r_changed <= n_changed;
            r_valid   <= n_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cur     <= n_cur;
        r_start   <= n_start;
        r_pmask   <= n_pmask;
        r_closure <= n_closure;
        r_success <= n_success;
        r_status  <= n_status;
    end

    assign busy          = (r_state != S_IDLE);
    assign o_valid       = r_valid;
    assign o_closure_set = r_closure;
    assign o_success     = r_success;
    assign o_status      = r_status;

endmodule

// ===== sv/ice_checker.sv =====
// Port-level checker for the implication closure engine, bound to the top.
module ice_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       start,
    input logic                       busy,
    input logic                       o_valid,
    input logic [ice_pkg::SET_W-1:0]  o_closure_set,
    input logic                       o_success,
    input logic [1:0]                 o_status
);

    import ice_pkg::*;

    // An accepted word either starts a sweep or answers at once.
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_valid))
        else $error("accepted word neither answered nor started a sweep");

    // A result never coincides with a running sweep.
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while busy");

    // The end of a sweep always delivers its result.
    a_sweep_ends_in_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && $past(i_rst_n) && $fell(busy)) |-> o_valid)
        else $error("sweep ended without a result");

    // A failed word reports no closure and no success.
    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_PREFIX || o_status == ST_FULL))
            |-> (!o_success && o_closure_set == '0))
        else $error("failed word carries closure or success");

    // A good status always comes with success.
    a_ok_success: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_OK) |-> o_success)
        else $error("ok status without success");

endmodule

bind implication_closure_engine ice_checker u_ice_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_valid       (o_valid),
    .o_closure_set (o_closure_set),
    .o_success     (o_success),
    .o_status      (o_status)
);
